[src/smcd_pkg.sv]
package smcd_pkg;

	localparam logic [7:0]  HEADER_BYTE      = 8'hAA;
	localparam logic [7:0]  TRAILER_BYTE     = 8'h55;
	localparam logic [15:0] PULSE_MIN_RESET  = 16'd500;
	localparam logic [15:0] PULSE_MAX_RESET  = 16'd2500;
	localparam logic [15:0] PULSE_HOLD_RESET = 16'd1500;

	localparam int          CFG_ADDR_W       = 3;
	localparam logic        REG_PULSE_MIN    = 1'b0;
	localparam logic        REG_PULSE_MAX    = 1'b1;

	typedef enum logic [2:0] {
		POS_IDLE   = 3'd0,
		POS_MOT_LO = 3'd1,
		POS_MOT_HI = 3'd2,
		POS_SRV_LO = 3'd3,
		POS_SRV_HI = 3'd4,
		POS_CHECK  = 3'd5,
		POS_TRAIL  = 3'd6
	} frame_pos_t;

	typedef struct packed {
		logic [15:0] pulse_min;
		logic [15:0] pulse_max;
	} cfg_t;

	typedef struct packed {
		logic [15:0] servo_pulse;
		logic [15:0] motor_pulse;
		logic        servo_updated;
		logic        motor_updated;
	} result_t;

endpackage

[src/smcd_cfg_regs.sv]
module smcd_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [smcd_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output smcd_pkg::cfg_t                    cfg
);

	smcd_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic           reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	// byte address 4*i: word index is bit 2
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_min <= smcd_pkg::PULSE_MIN_RESET;
			cfg_q.pulse_max <= smcd_pkg::PULSE_MAX_RESET;
		end else if (wr_en) begin
			if (reg_sel == smcd_pkg::REG_PULSE_MIN) begin
				cfg_q.pulse_min <= pwdata[15:0];
			end else begin
				cfg_q.pulse_max <= pwdata[15:0];
			end
		end
	end

	always_comb begin
		if (reg_sel == smcd_pkg::REG_PULSE_MIN) begin
			prdata = {16'd0, cfg_q.pulse_min};
		end else begin
			prdata = {16'd0, cfg_q.pulse_max};
		end
	end

	assign cfg = cfg_q;

endmodule

[src/smcd_parser.sv]
module smcd_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	input  logic [7:0]           rx_byte,
	input  smcd_pkg::cfg_t       cfg,
	output logic                 res_valid,
	output smcd_pkg::result_t    res
);

	smcd_pkg::frame_pos_t pos_q;
	smcd_pkg::frame_pos_t pos_d;
	logic [7:0]           sum_q;
	logic [15:0]          motor_q;
	logic [15:0]          servo_q;
	logic [15:0]          held_servo_q;
	logic [15:0]          held_motor_q;
	logic                 s_ok;
	logic                 m_ok;
	logic                 frame_done;

	assign s_ok = (servo_q >= cfg.pulse_min) && (servo_q <= cfg.pulse_max);
	assign m_ok = (motor_q >= cfg.pulse_min) && (motor_q <= cfg.pulse_max);

	// next state
	always_comb begin
		case (pos_q)
			smcd_pkg::POS_MOT_LO: pos_d = smcd_pkg::POS_MOT_HI;
			smcd_pkg::POS_MOT_HI: pos_d = smcd_pkg::POS_SRV_LO;
			smcd_pkg::POS_SRV_LO: pos_d = smcd_pkg::POS_SRV_HI;
			smcd_pkg::POS_SRV_HI: pos_d = smcd_pkg::POS_CHECK;
			smcd_pkg::POS_CHECK: begin
				// bad checksum: back to idle, next byte is tried as a header
				pos_d = (rx_byte == sum_q) ? smcd_pkg::POS_TRAIL : smcd_pkg::POS_IDLE;
			end
			smcd_pkg::POS_TRAIL: pos_d = smcd_pkg::POS_IDLE;
			default: begin
				pos_d = (rx_byte == smcd_pkg::HEADER_BYTE) ? smcd_pkg::POS_MOT_LO
				                                           : smcd_pkg::POS_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		frame_done        = (pos_q == smcd_pkg::POS_TRAIL) && (rx_byte == smcd_pkg::TRAILER_BYTE);
		res_valid         = byte_valid && frame_done;
		res.servo_pulse   = s_ok ? servo_q : held_servo_q;
		res.motor_pulse   = m_ok ? motor_q : held_motor_q;
		res.servo_updated = s_ok;
		res.motor_updated = m_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= smcd_pkg::POS_IDLE;
			sum_q        <= 8'd0;
			motor_q      <= 16'd0;
			servo_q      <= 16'd0;
			held_servo_q <= smcd_pkg::PULSE_HOLD_RESET;
			held_motor_q <= smcd_pkg::PULSE_HOLD_RESET;
		end else if (byte_valid) begin
			pos_q <= pos_d;
			case (pos_q)
				smcd_pkg::POS_MOT_LO: begin
					motor_q <= {8'd0, rx_byte};
					sum_q   <= rx_byte;
				end
				smcd_pkg::POS_MOT_HI: begin
					motor_q <= {rx_byte, motor_q[7:0]};
					sum_q   <= sum_q + rx_byte;
				end
				smcd_pkg::POS_SRV_LO: begin
					servo_q <= {8'd0, rx_byte};
					sum_q   <= sum_q + rx_byte;
				end
				smcd_pkg::POS_SRV_HI: begin
					servo_q <= {rx_byte, servo_q[7:0]};
					sum_q   <= sum_q + rx_byte;
				end
				smcd_pkg::POS_TRAIL: begin
					if (frame_done) begin
						held_servo_q <= res.servo_pulse;
						held_motor_q <= res.motor_pulse;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[src/smcd_out_buf.sv]
module smcd_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  smcd_pkg::result_t    push_data,
	output logic                 space,
	output logic                 out_valid,
	input  logic                 out_stall,
	output smcd_pkg::result_t    out_data
);

	smcd_pkg::result_t out_q;
	smcd_pkg::result_t skid_q;
	logic              out_valid_q;
	logic              skid_valid_q;
	logic              pop;

	assign pop   = out_valid_q && !out_stall;
	assign space = !(out_valid_q && skid_valid_q) || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_skid_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without a head entry");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> space)
		else $error("result pushed into a full buffer");

	a_skid_refills_head: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && pop) |=> out_valid_q)
		else $error("head not refilled from skid entry");

endmodule

[src/servo_motor_command_deframer.sv]
// A byte accepted at the input is registered in valid_s1/byte_s1; if it closes a
// valid frame, its result is registered into the result buffer and shown at
// out_valid. Throughput: one byte per cycle, set by the frame FSM and the
// two-entry result buffer; input stalls only while that buffer is full.
// Reset (arst_n low, async): idle, pulse window 500..2500, both held pulses 1500.
module servo_motor_command_deframer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [smcd_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        rx_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [15:0]                       servo_pulse,
	output logic [15:0]                       motor_pulse,
	output logic                              servo_updated,
	output logic                              motor_updated
);

	smcd_pkg::cfg_t    cfg;
	smcd_pkg::result_t res;
	smcd_pkg::result_t out_data;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              space;
	logic              proc_s1;
	logic              res_valid;

	smcd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign proc_s1  = valid_s1 && space;
	assign in_stall = valid_s1 && !space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	smcd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (proc_s1),
		.rx_byte    (byte_s1),
		.cfg        (cfg),
		.res_valid  (res_valid),
		.res        (res)
	);

	smcd_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.space     (space),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign servo_pulse   = out_data.servo_pulse;
	assign motor_pulse   = out_data.motor_pulse;
	assign servo_updated = out_data.servo_updated;
	assign motor_updated = out_data.motor_updated;

endmodule
